[rtl/component_stream_segmenter_macros.svh]
// ---------------------------------------------------------------------------
// component stream segmenter assertion macros
// shared concurrent assertion forms, clocked on clk, off during reset
// ---------------------------------------------------------------------------
`ifndef COMPONENT_STREAM_SEGMENTER_MACROS_SVH
`define COMPONENT_STREAM_SEGMENTER_MACROS_SVH

// same-cycle implication
`define CSS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("component_stream_segmenter: assertion failed");

// next-cycle implication
`define CSS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("component_stream_segmenter: assertion failed");

`endif

[rtl/css_pkg.sv]
// ---------------------------------------------------------------------------
// css_pkg
// widths, codes and the result record of the component stream segmenter
// ---------------------------------------------------------------------------
package css_pkg;

	// widths and sizes
	localparam int BEAT       = 8;
	localparam int BEAT_W     = $clog2(BEAT + 1);
	localparam int OFF_W      = 48;
	localparam int CHUNK_W    = 32;
	localparam int MODE_W     = 2;
	localparam int CNT_W      = 4;
	localparam int KIND_W     = 3;
	localparam int QDEPTH     = 4;
	localparam int QCNT_W     = $clog2(QDEPTH + 1);

	localparam logic [CHUNK_W-1:0] CHUNK_RESET = CHUNK_W'(1048576);

	// request modes
	localparam logic [MODE_W-1:0] MODE_WRITE         = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BEGIN_CHUNKED = 2'd1;
	localparam logic [MODE_W-1:0] MODE_BEGIN_WHOLE   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_END           = 2'd3;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_CHUNK        = 3'd0;
	localparam logic [KIND_W-1:0] KIND_CHUNKED_DONE = 3'd1;
	localparam logic [KIND_W-1:0] KIND_WHOLE_DONE   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_BUSY         = 3'd3;
	localparam logic [KIND_W-1:0] KIND_DIVERGED     = 3'd4;
	localparam logic [KIND_W-1:0] KIND_NO_COMPONENT = 3'd5;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [OFF_W-1:0]  offset;
		logic [OFF_W-1:0]  length;
		logic [OFF_W-1:0]  head_base;
		logic [OFF_W-1:0]  head_left;
		logic [OFF_W-1:0]  io_left;
		logic              last;
	} res_t;

endpackage

[rtl/css_in_if.sv]
// ---------------------------------------------------------------------------
// css_in_if
// request channel: write beats and component begin/end events
// ---------------------------------------------------------------------------
interface css_in_if import css_pkg::*; ();

	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [CNT_W-1:0]  byte_count;
	logic [OFF_W-1:0]  head_bytes;
	logic [OFF_W-1:0]  io_bytes;

	modport source (output valid, output mode, output byte_count, output head_bytes,
		output io_bytes, input ready);
	modport sink (input valid, input mode, input byte_count, input head_bytes,
		input io_bytes, output ready);

endinterface

[rtl/css_out_if.sv]
// ---------------------------------------------------------------------------
// css_out_if
// result channel: chunk records, completions and errors
// ---------------------------------------------------------------------------
interface css_out_if import css_pkg::*; ();

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [OFF_W-1:0]  offset;
	logic [OFF_W-1:0]  length;
	logic [OFF_W-1:0]  head_base;
	logic [OFF_W-1:0]  head_left;
	logic [OFF_W-1:0]  io_left;
	logic              last;

	modport source (output valid, output kind, output offset, output length,
		output head_base, output head_left, output io_left, output last, input ready);
	modport sink (input valid, input kind, input offset, input length,
		input head_base, input head_left, input io_left, input last, output ready);

endinterface

[rtl/component_stream_segmenter.sv]
// ---------------------------------------------------------------------------
// component_stream_segmenter
// lays a serialized byte stream out as components and reports chunk records
// ---------------------------------------------------------------------------
// usage:
//   items   : valid/ready request channel; mode selects write beat, begin
//             chunked, begin whole or end. one request per cycle is taken while ready is high.
//   results : valid/ready channel of result records; last marks the final
//             record caused by one request (a write beat may give two).
//   cfg_wen / cfg_wdata : chunk size write, only while the block is idle.
// output: with an empty queue the first record of a request is on the
//   result port in the cycle after the request is taken; a second record of
//   the same request reaches the queue head once the first one is popped.
// throughput: one request per cycle while ready, one result per cycle while the
//   receiver takes it. the request side is ready while the 4-entry result queue
//   holds at most two records, so two-record requests wait on the queue draining.
// reset: cursor, extents and frame state clear, stage is outside, queue is
//   empty and the chunk size returns to 1048576.
// stall: a stalled receiver holds the queue head; requests keep flowing
//   until the queue cannot take two more records.
// ---------------------------------------------------------------------------
`include "component_stream_segmenter_macros.svh"

module component_stream_segmenter import css_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wen,
	input  logic [CHUNK_W-1:0] cfg_wdata,
	css_in_if.sink             items,
	css_out_if.source          results
);

	// stage codes
	localparam logic [2:0] ST_OUTSIDE = 3'd0;
	localparam logic [2:0] ST_HEAD    = 3'd1;
	localparam logic [2:0] ST_IO      = 3'd2;
	localparam logic [2:0] ST_TAIL    = 3'd3;
	localparam logic [2:0] ST_WHOLE   = 3'd4;

	// layout state
	logic [2:0]         stage_q, stage_d;
	logic [OFF_W-1:0]   cursor_q, cursor_d;
	logic [OFF_W-1:0]   hrem_q, hrem_d;
	logic [OFF_W-1:0]   iorem_q, iorem_d;
	logic [CHUNK_W-1:0] frem_q, frem_d;
	logic [OFF_W-1:0]   fstart_q, fstart_d;
	logic [OFF_W-1:0]   ffill_q, ffill_d;
	logic               fopen_q, fopen_d;
	logic [OFF_W-1:0]   tstart_q, tstart_d;
	logic [OFF_W-1:0]   hstart_q, hstart_d;
	logic               active_q, active_d;
	logic [CHUNK_W-1:0] chunk_eff_q;

	// result queue
	res_t               q_q [QDEPTH];
	res_t               q_d [QDEPTH];
	logic [QCNT_W-1:0]  cnt_q, cnt_d, base;
	res_t               res_a, res_b;
	logic [1:0]         push_n, push_cnt;
	logic               acc, pop;

	// beat datapath
	logic [BEAT_W-1:0]  beat_len, th, pos0, r0, t1, pos1, r1, t2, pos2, r2, tail_pos;
	logic [OFF_W-1:0]   hrem_n, io1, io2, fst1, fst2, ffl1, fill1n, end_ts;
	logic [CHUNK_W-1:0] eff_io0, eff_io1, frem1, frem1n, frem2n;
	logic               head_done, io_run, close1, close2, go_tail, to_tail;

	function automatic res_t chunk_rec(input logic [OFF_W-1:0] off,
		input logic [OFF_W-1:0] len, input logic [OFF_W-1:0] hoff);
		res_t r;
		r           = '0;
		r.kind      = KIND_CHUNK;
		r.offset    = off;
		r.length    = len;
		r.head_base = hoff;
		return r;
	endfunction

	assign acc         = items.valid && items.ready;
	assign pop         = results.valid && results.ready;
	assign items.ready = (cnt_q <= QCNT_W'(QDEPTH - 2));

	// clamp beat and consume head bytes
	always_comb begin
		beat_len  = (items.byte_count > CNT_W'(BEAT)) ? BEAT_W'(BEAT)
			: BEAT_W'(items.byte_count);
		th        = (hrem_q < OFF_W'(beat_len)) ? hrem_q[BEAT_W-1:0] : beat_len;
		hrem_n    = hrem_q - OFF_W'(th);
		head_done = (hrem_n == '0);
		io_run    = (stage_q == ST_IO) || (stage_q == ST_HEAD && head_done);
		pos0      = (stage_q == ST_HEAD) ? th : '0;
		r0        = beat_len - pos0;
	end

	// first io frame: the open one or a new one at the cursor
	always_comb begin
		eff_io0 = (iorem_q < OFF_W'(chunk_eff_q)) ? iorem_q[CHUNK_W-1:0] : chunk_eff_q;
		frem1   = fopen_q ? frem_q : eff_io0;
		fst1    = fopen_q ? fstart_q : cursor_q + OFF_W'(pos0);
		ffl1    = fopen_q ? ffill_q : '0;
		t1      = (frem1 < CHUNK_W'(r0)) ? frem1[BEAT_W-1:0] : r0;
		frem1n  = frem1 - CHUNK_W'(t1);
		io1     = iorem_q - OFF_W'(t1);
		fill1n  = ffl1 + OFF_W'(t1);
		close1  = (frem1n == '0);
		pos1    = pos0 + t1;
		r1      = r0 - t1;
	end

	// second io frame, opened after the first one closes inside the beat
	always_comb begin
		eff_io1 = (io1 < OFF_W'(chunk_eff_q)) ? io1[CHUNK_W-1:0] : chunk_eff_q;
		fst2    = cursor_q + OFF_W'(pos1);
		t2      = (eff_io1 < CHUNK_W'(r1)) ? eff_io1[BEAT_W-1:0] : r1;
		frem2n  = eff_io1 - CHUNK_W'(t2);
		io2     = io1 - OFF_W'(t2);
		close2  = (frem2n == '0);
		pos2    = pos1 + t2;
		r2      = r1 - t2;
	end

	// end event: io turns into tail
	assign to_tail = (stage_q == ST_IO) && (iorem_q == '0) && !fopen_q;
	assign end_ts  = to_tail ? cursor_q : tstart_q;

	// next state and results of one request
	always_comb begin
		stage_d  = stage_q;
		cursor_d = cursor_q;
		hrem_d   = hrem_q;
		iorem_d  = iorem_q;
		frem_d   = frem_q;
		fstart_d = fstart_q;
		ffill_d  = ffill_q;
		fopen_d  = fopen_q;
		tstart_d = tstart_q;
		hstart_d = hstart_q;
		active_d = active_q;
		res_a    = '0;
		res_b    = '0;
		push_n   = 2'd0;
		go_tail  = 1'b0;
		tail_pos = '0;
		unique case (items.mode)
			MODE_WRITE: begin
				cursor_d = cursor_q + OFF_W'(beat_len);
				if (stage_q == ST_WHOLE) begin
					ffill_d = ffill_q + OFF_W'(beat_len);
				end
				if (stage_q == ST_HEAD) begin
					hrem_d = hrem_n;
					if (head_done) begin
						stage_d = ST_IO;
					end
				end
				if (io_run && r0 != '0) begin
					if (iorem_q == '0) begin
						go_tail  = 1'b1;
						tail_pos = pos0;
					end else begin
						iorem_d  = io1;
						fopen_d  = !close1;
						fstart_d = fst1;
						ffill_d  = fill1n;
						frem_d   = frem1n;
						if (close1) begin
							res_a  = chunk_rec(fst1, fill1n, hstart_q);
							push_n = 2'd1;
						end
						if (r1 != '0) begin
							if (io1 == '0) begin
								go_tail  = 1'b1;
								tail_pos = pos1;
							end else begin
								iorem_d  = io2;
								fopen_d  = !close2;
								fstart_d = fst2;
								ffill_d  = OFF_W'(t2);
								frem_d   = frem2n;
								if (close2) begin
									res_b  = chunk_rec(fst2, OFF_W'(t2), hstart_q);
									push_n = 2'd2;
								end
								if (r2 != '0) begin
									go_tail  = 1'b1;
									tail_pos = pos2;
								end
							end
						end
					end
				end
				if (go_tail) begin
					stage_d  = ST_TAIL;
					tstart_d = cursor_q + OFF_W'(tail_pos);
				end
			end
			MODE_BEGIN_CHUNKED, MODE_BEGIN_WHOLE: begin
				if (stage_q != ST_OUTSIDE) begin
					res_a.kind = KIND_BUSY;
					push_n     = 2'd1;
				end else if (items.mode == MODE_BEGIN_CHUNKED) begin
					hstart_d = cursor_q;
					hrem_d   = items.head_bytes;
					iorem_d  = items.io_bytes;
					stage_d  = (items.head_bytes != '0) ? ST_HEAD : ST_IO;
					active_d = 1'b1;
				end else begin
					fstart_d = cursor_q;
					ffill_d  = '0;
					fopen_d  = 1'b1;
					stage_d  = ST_WHOLE;
					active_d = 1'b1;
				end
			end
			MODE_END: begin
				push_n = 2'd1;
				if (!active_q || stage_q == ST_OUTSIDE) begin
					res_a.kind = KIND_NO_COMPONENT;
				end else if (stage_q == ST_WHOLE) begin
					res_a.kind      = KIND_WHOLE_DONE;
					res_a.offset    = fstart_q;
					res_a.length    = ffill_q;
					res_a.head_base = fstart_q;
					fopen_d         = 1'b0;
					stage_d         = ST_OUTSIDE;
					active_d        = 1'b0;
				end else if ((!to_tail && stage_q != ST_TAIL) || hrem_q != '0
					|| iorem_q != '0) begin
					res_a.kind      = KIND_DIVERGED;
					res_a.head_base = hstart_q;
					res_a.head_left = hrem_q;
					res_a.io_left   = iorem_q;
				end else begin
					res_a.kind      = KIND_CHUNKED_DONE;
					res_a.offset    = end_ts;
					res_a.length    = cursor_q - end_ts;
					res_a.head_base = hstart_q;
					tstart_d        = end_ts;
					stage_d         = ST_OUTSIDE;
					active_d        = 1'b0;
				end
			end
		endcase
		// mark the final record of the request
		if (push_n == 2'd2) begin
			res_b.last = 1'b1;
		end else if (push_n == 2'd1) begin
			res_a.last = 1'b1;
		end
	end

	// result queue: shift on pop, append up to two records
	always_comb begin
		push_cnt = acc ? push_n : 2'd0;
		base     = cnt_q - QCNT_W'(pop);
		cnt_d    = base + QCNT_W'(push_cnt);
		q_d      = q_q;
		if (pop) begin
			for (int i = 0; i < QDEPTH - 1; i++) begin
				q_d[i] = q_q[i + 1];
			end
		end
		for (int i = 0; i < QDEPTH; i++) begin
			if (push_cnt != 2'd0 && QCNT_W'(i) == base) begin
				q_d[i] = res_a;
			end
			if (push_cnt == 2'd2 && QCNT_W'(i) == base + QCNT_W'(1)) begin
				q_d[i] = res_b;
			end
		end
	end

	always_ff @(posedge clk) begin
		q_q <= q_d;
	end

	// control and layout registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q     <= ST_OUTSIDE;
			cursor_q    <= '0;
			hrem_q      <= '0;
			iorem_q     <= '0;
			frem_q      <= '0;
			fstart_q    <= '0;
			ffill_q     <= '0;
			fopen_q     <= 1'b0;
			tstart_q    <= '0;
			hstart_q    <= '0;
			active_q    <= 1'b0;
			chunk_eff_q <= CHUNK_RESET;
			cnt_q       <= '0;
		end else begin
			if (cfg_wen) begin
				chunk_eff_q <= (cfg_wdata < CHUNK_W'(BEAT)) ? CHUNK_W'(BEAT) : cfg_wdata;
			end
			if (acc) begin
				stage_q  <= stage_d;
				cursor_q <= cursor_d;
				hrem_q   <= hrem_d;
				iorem_q  <= iorem_d;
				frem_q   <= frem_d;
				fstart_q <= fstart_d;
				ffill_q  <= ffill_d;
				fopen_q  <= fopen_d;
				tstart_q <= tstart_d;
				hstart_q <= hstart_d;
				active_q <= active_d;
			end
			cnt_q <= cnt_d;
		end
	end

	// output drive from queue head
	assign results.valid     = (cnt_q != '0);
	assign results.kind      = q_q[0].kind;
	assign results.offset    = q_q[0].offset;
	assign results.length    = q_q[0].length;
	assign results.head_base = q_q[0].head_base;
	assign results.head_left = q_q[0].head_left;
	assign results.io_left   = q_q[0].io_left;
	assign results.last      = q_q[0].last;

	// checks
	`CSS_ASSERT_IMP(a_stage_active, 1'b1, (stage_q == ST_OUTSIDE) == !active_q)
	`CSS_ASSERT_IMP(a_open_frame_nonempty, stage_q == ST_IO && fopen_q, frem_q != '0)
	`CSS_ASSERT_IMP(a_head_nonempty, stage_q == ST_HEAD, hrem_q != '0)
	`CSS_ASSERT_NEXT(a_cursor_advance, acc && items.mode == MODE_WRITE, cursor_q == $past(cursor_q) + OFF_W'($past(beat_len)))

endmodule
